>>> rtl/mrc_pkg.sv
// mixed-radix index codec: shared constants, flow types and the division step
// used by every dimension cell; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mrc_pkg;

   localparam int DIM_COUNT      = 8;
   localparam int MAX_RADIX      = 256;
   localparam int NUM_REGS       = 8;
   localparam int IDX_W          = 32;
   localparam int DIGIT_W        = 8;
   localparam int RADIX_W        = 9;
   localparam int REG_IDX_W      = 3;
   localparam int BITS_PER_STAGE = 4;
   localparam int DIV_STAGES     = IDX_W / BITS_PER_STAGE;

   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   // data handed from one dimension cell to the next
   typedef struct packed {
      logic                                op;
      logic [IDX_W-1:0]                    running;
      logic [IDX_W-1:0]                    stride;
      logic [IDX_W-1:0]                    acc;
      logic [DIM_COUNT-1:0][DIGIT_W-1:0]   dig_in;
      logic [DIM_COUNT-1:0][DIGIT_W-1:0]   dig_out;
   } mrc_flow_type;

   // one pipeline stage inside a cell
   typedef struct packed {
      mrc_flow_type       flow;
      logic [DIGIT_W-1:0] rem;
      logic [IDX_W-1:0]   prod;
   } mrc_stage_type;

   // BITS_PER_STAGE restoring division steps: quotient bits shift into running
   function automatic mrc_stage_type mrc_div_step(mrc_stage_type s,
                                                  logic [RADIX_W-1:0] radix);
      mrc_stage_type        r;
      logic [RADIX_W-1:0]   t;
      r = s;
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
         t = {r.rem, r.flow.running[IDX_W-1]};
         r.flow.running = {r.flow.running[IDX_W-2:0], 1'b0};
         if (t >= radix) begin
            t = t - radix;
            r.flow.running[0] = 1'b1;
         end
         r.rem = t[DIGIT_W-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> rtl/mrc_cell.sv
// one dimension cell: pipelined divide by its radix for decode, stride
// multiply and accumulate for encode; depends on mrc_pkg
`timescale 1ns / 1ps
`default_nettype none
module mrc_cell
   import mrc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire mrc_flow_type        in_flow,
   input  wire logic [RADIX_W-1:0]  radix,
   output logic                     out_valid,
   output mrc_flow_type             out_flow
);

   mrc_stage_type                 st_ff [DIV_STAGES];
   mrc_stage_type                 st_in [DIV_STAGES];
   logic [DIV_STAGES-1:0]         valid_ff;
   logic [DIV_STAGES-1:0]         valid_in;

   always_comb begin
      mrc_stage_type cur;
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (k == 0) begin
            cur.flow = in_flow;
            cur.rem  = '0;
            cur.prod = IDX_W'(IDX_W'(in_flow.dig_in[0]) * in_flow.stride);
            cur.flow.stride = IDX_W'(in_flow.stride * IDX_W'(radix));
            for (int j = 0; j < DIM_COUNT - 1; j++) begin
               cur.flow.dig_in[j] = in_flow.dig_in[j+1];
            end
            cur.flow.dig_in[DIM_COUNT-1] = '0;
            valid_in[k] = in_valid;
         end else begin
            cur = st_ff[k-1];
            // accumulate one stage after the product
            if (k == 1) begin
               cur.flow.acc = cur.flow.acc + cur.prod;
            end
            valid_in[k] = valid_ff[k-1];
         end
         st_in[k] = mrc_div_step(cur, radix);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DIV_STAGES; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   // on decode the remainder becomes this dimension's digit (zero on encode), shifted in at the top
   always_comb begin
      out_flow = st_ff[DIV_STAGES-1].flow;
      for (int j = 0; j < DIM_COUNT - 1; j++) begin
         out_flow.dig_out[j] = st_ff[DIV_STAGES-1].flow.dig_out[j+1];
      end
      out_flow.dig_out[DIM_COUNT-1] = (st_ff[DIV_STAGES-1].flow.op == OP_DECODE) ?
                                      st_ff[DIV_STAGES-1].rem : '0;
      out_valid = valid_ff[DIV_STAGES-1];
   end

endmodule
`default_nettype wire

>>> rtl/mixed_radix_index_codec_top.sv
// mixed-radix index codec top level: radix registers, chain of dimension
// cells and output register; depends on mrc_pkg and mrc_cell
// each dimension cell registers all DIV_STAGES stages of its 4-bit-per-stage
// divider, and a final output register follows the chain of cells
// throughput: one request per cycle; the whole chain holds while a result
// waits at the output
// reset: synchronous, clears all valid bits and sets every radix to 1
`timescale 1ns / 1ps
`default_nettype none
module mixed_radix_index_codec_top
   import mrc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // configuration
   input  wire logic                  csr_we,
   input  wire logic [REG_IDX_W-1:0]  csr_index,
   input  wire logic [RADIX_W-1:0]    csr_wdata,
   // request channel
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_op,
   input  wire logic [IDX_W-1:0]      req_flat_index,
   input  wire logic [DIGIT_W-1:0]    req_digit_in_zero,
   input  wire logic [DIGIT_W-1:0]    req_digit_in_one,
   input  wire logic [DIGIT_W-1:0]    req_digit_in_two,
   input  wire logic [DIGIT_W-1:0]    req_digit_in_three,
   input  wire logic [DIGIT_W-1:0]    req_digit_in_four,
   input  wire logic [DIGIT_W-1:0]    req_digit_in_five,
   input  wire logic [DIGIT_W-1:0]    req_digit_in_six,
   input  wire logic [DIGIT_W-1:0]    req_digit_in_seven,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [IDX_W-1:0]           rsp_encoded_index,
   output logic [IDX_W-1:0]           rsp_total_count,
   output logic [DIGIT_W-1:0]         rsp_digit_out_zero,
   output logic [DIGIT_W-1:0]         rsp_digit_out_one,
   output logic [DIGIT_W-1:0]         rsp_digit_out_two,
   output logic [DIGIT_W-1:0]         rsp_digit_out_three,
   output logic [DIGIT_W-1:0]         rsp_digit_out_four,
   output logic [DIGIT_W-1:0]         rsp_digit_out_five,
   output logic [DIGIT_W-1:0]         rsp_digit_out_six,
   output logic [DIGIT_W-1:0]         rsp_digit_out_seven
);

   // effective radix per register, already clamped to 1..MAX_RADIX
   logic [RADIX_W-1:0]   radix_ff [NUM_REGS];
   logic [RADIX_W-1:0]   radix_in;

   logic [DIGIT_W-1:0]   dig_req  [NUM_REGS];
   logic [DIGIT_W-1:0]   dig_rsp  [NUM_REGS];

   mrc_flow_type         flow     [DIM_COUNT+1];
   logic                 valid    [DIM_COUNT+1];

   mrc_flow_type         rsp_flow_ff;
   logic                 rsp_valid_ff;
   logic                 advance;

   // radix register writes, zero reads as one, large values clamp
   always_comb begin
      if (csr_wdata == '0) begin
         radix_in = RADIX_W'(1);
      end else if (csr_wdata > RADIX_W'(MAX_RADIX)) begin
         radix_in = RADIX_W'(MAX_RADIX);
      end else begin
         radix_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            radix_ff[i] <= RADIX_W'(1);
         end
      end else if (csr_we) begin
         radix_ff[csr_index] <= radix_in;
      end
   end

   // whole chain moves when the output slot is free or being drained
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   assign dig_req[0] = req_digit_in_zero;
   assign dig_req[1] = req_digit_in_one;
   assign dig_req[2] = req_digit_in_two;
   assign dig_req[3] = req_digit_in_three;
   assign dig_req[4] = req_digit_in_four;
   assign dig_req[5] = req_digit_in_five;
   assign dig_req[6] = req_digit_in_six;
   assign dig_req[7] = req_digit_in_seven;

   // request enters the first cell with unit stride and empty sum
   always_comb begin
      flow[0].op      = req_op;
      flow[0].running = req_flat_index;
      flow[0].stride  = IDX_W'(1);
      flow[0].acc     = '0;
      flow[0].dig_out = '0;
      for (int j = 0; j < DIM_COUNT; j++) begin
         flow[0].dig_in[j] = dig_req[j];
      end
      valid[0] = req_valid;
   end

   // one cell per dimension, least significant first
   for (genvar g = 0; g < DIM_COUNT; g++) begin : g_cell
      mrc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (advance),
         .in_valid  (valid[g]),
         .in_flow   (flow[g]),
         .radix     (radix_ff[g]),
         .out_valid (valid[g+1]),
         .out_flow  (flow[g+1])
      );
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid[DIM_COUNT];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_flow_ff <= flow[DIM_COUNT];
      end
   end

   // final stride is the product of all radices
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_total_count   = rsp_flow_ff.stride;
   assign rsp_encoded_index = (rsp_flow_ff.op == OP_ENCODE) ? rsp_flow_ff.acc : '0;

   // dimensions beyond the configured count read as zero
   always_comb begin
      for (int i = 0; i < NUM_REGS; i++) begin
         dig_rsp[i] = '0;
      end
      for (int i = 0; i < DIM_COUNT; i++) begin
         dig_rsp[i] = rsp_flow_ff.dig_out[i];
      end
   end

   assign rsp_digit_out_zero  = dig_rsp[0];
   assign rsp_digit_out_one   = dig_rsp[1];
   assign rsp_digit_out_two   = dig_rsp[2];
   assign rsp_digit_out_three = dig_rsp[3];
   assign rsp_digit_out_four  = dig_rsp[4];
   assign rsp_digit_out_five  = dig_rsp[5];
   assign rsp_digit_out_six   = dig_rsp[6];
   assign rsp_digit_out_seven = dig_rsp[7];

endmodule
`default_nettype wire
